@@ hdl/afk_pkg.sv @@
// ----------------------------------------------------------------------------
// afk_pkg
// Shared types, constants and helpers for the four-joint arm pose pipeline.
// ----------------------------------------------------------------------------
package afk_pkg;

   // Width of the internal phase word that the sine units work on.
   localparam int ANGLE_WIDTH = 16;

   // Field widths fixed by the interface.
   localparam int IN_WIDTH   = 16;
   localparam int OUT_WIDTH  = 16;
   localparam int LINK_WIDTH = 10;
   localparam int CSR_INDEX_WIDTH = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BASE_HEIGHT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UPPER_LINK  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FORE_LINK   = 2'd2;

   localparam logic [LINK_WIDTH-1:0] BASE_HEIGHT_RESET = 10'd86;
   localparam logic [LINK_WIDTH-1:0] UPPER_LINK_RESET  = 10'd135;
   localparam logic [LINK_WIDTH-1:0] FORE_LINK_RESET   = 10'd89;

   // Q30 constants of the polynomial sine.
   localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;
   localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

   // Horner steps of the odd Taylor series through x^11. Each step divides
   // by a constant; the division is an exact reciprocal multiply for any
   // 32-bit numerator: floor(n / d) = (n * ceil(2^s / d)) >> s.
   localparam int TAYLOR_STEPS = 5;
   localparam int DIV_SHIFT [TAYLOR_STEPS] = '{39, 39, 38, 37, 35};
   localparam logic [32:0] DIV_MUL [TAYLOR_STEPS] = '{
      33'(((64'd1 << 39) + 64'd109) / 64'd110),
      33'(((64'd1 << 39) + 64'd71) / 64'd72),
      33'(((64'd1 << 38) + 64'd41) / 64'd42),
      33'(((64'd1 << 37) + 64'd19) / 64'd20),
      33'(((64'd1 << 35) + 64'd5) / 64'd6)
   };

   // Three register stages per Horner step.
   localparam int CARRY_LEN    = 3 * TAYLOR_STEPS;
   localparam int SINE_LATENCY = CARRY_LEN + 4;
   localparam int POSE_LATENCY = 3;
   localparam int PIPE_DEPTH   = 1 + SINE_LATENCY + POSE_LATENCY;

   typedef struct packed {
      logic signed [IN_WIDTH-1:0] base_angle;
      logic signed [IN_WIDTH-1:0] shoulder_angle;
      logic signed [IN_WIDTH-1:0] elbow_angle;
      logic signed [IN_WIDTH-1:0] wrist_angle;
   } req_payload_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] normal_x;
      logic signed [OUT_WIDTH-1:0] orient_x;
      logic signed [OUT_WIDTH-1:0] approach_x;
      logic signed [OUT_WIDTH-1:0] normal_y;
      logic signed [OUT_WIDTH-1:0] orient_y;
      logic signed [OUT_WIDTH-1:0] approach_y;
      logic signed [OUT_WIDTH-1:0] normal_z;
      logic signed [OUT_WIDTH-1:0] orient_z;
      logic signed [OUT_WIDTH-1:0] pos_x;
      logic signed [OUT_WIDTH-1:0] pos_y;
      logic signed [OUT_WIDTH-1:0] pos_z;
   } rsp_payload_type;

   // Sines and cosines handed from the sine units to the pose stages.
   typedef struct packed {
      logic signed [15:0] s1;
      logic signed [15:0] c1;
      logic signed [15:0] s2;
      logic signed [15:0] c2;
      logic signed [15:0] s23;
      logic signed [15:0] c23;
      logic signed [15:0] s4;
      logic signed [15:0] c4;
   } trig_type;

   // Values that ride along the Horner stages of a sine unit.
   typedef struct packed {
      logic [30:0] x;
      logic [31:0] x2;
      logic        neg;
   } sine_carry_type;

   // A 16-bit binary angle as an ANGLE_WIDTH-bit phase: the top bits of
   // the angle followed by zeros.
   function automatic logic [ANGLE_WIDTH-1:0] to_phase(input logic [IN_WIDTH-1:0] a);
      logic [IN_WIDTH+ANGLE_WIDTH-1:0] ext;
      ext = {a, {ANGLE_WIDTH{1'b0}}};
      return ext[IN_WIDTH+ANGLE_WIDTH-1 -: ANGLE_WIDTH];
   endfunction

endpackage

@@ hdl/afk_sine.sv @@
// ----------------------------------------------------------------------------
// afk_sine
// Pipelined Q14 sine of a binary phase: quadrant fold, Taylor polynomial
// in Horner form with truncated Q30 products, rounding and sign.
// ----------------------------------------------------------------------------
module afk_sine (
   input  logic                             clock,
   input  logic                             en,
   input  logic [afk_pkg::ANGLE_WIDTH-1:0]  phase,
   output logic signed [15:0]               sine
);

   localparam int W = afk_pkg::ANGLE_WIDTH;
   localparam int N = afk_pkg::TAYLOR_STEPS;
   localparam int C = afk_pkg::CARRY_LEN;

   logic [1:0]   quad;
   logic [W-3:0] rem;
   logic [W-2:0] m_in;

   logic [W+29:0] xprod_ff;
   logic          neg0_ff;
   logic [30:0]   x_ff;
   logic [61:0]   sq_ff;
   logic          neg1_ff;

   afk_pkg::sine_carry_type car [0:C];
   afk_pkg::sine_carry_type car_ff [1:C];

   logic [62:0] p_ff [N];
   logic [64:0] r_ff [N];
   logic [30:0] t_ff [N];
   logic [30:0] t_in [N];
   logic [31:0] d    [N];

   logic [61:0] sprod_ff;
   logic        neg_f_ff;
   logic [31:0] s_val;
   logic [16:0] s_rnd;
   logic [15:0] s_cap;
   logic signed [15:0] sine_ff;

   // Quadrants one and three mirror the remainder about a quarter turn.
   assign quad = phase[W-1 -: 2];
   assign rem  = phase[W-3:0];
   assign m_in = quad[0] ? ((W-1)'(1) << (W-2)) - {1'b0, rem} : {1'b0, rem};

   always_ff @(posedge clock) begin
      if (en) begin
         xprod_ff <= (W+30)'(m_in) * (W+30)'(afk_pkg::HALFPI_Q30);
         neg0_ff  <= quad[1];
         x_ff     <= 31'(xprod_ff >> (W-2));
         sq_ff    <= 62'(31'(xprod_ff >> (W-2))) * 62'(31'(xprod_ff >> (W-2)));
         neg1_ff  <= neg0_ff;
      end
   end

   assign car[0] = '{x: x_ff, x2: sq_ff[61:30], neg: neg1_ff};

   for (genvar k = 1; k <= C; k++) begin : g_carry
      always_ff @(posedge clock) begin
         if (en) begin
            car_ff[k] <= car[k-1];
         end
      end
      assign car[k] = car_ff[k];
   end

   for (genvar i = 0; i < N; i++) begin : g_horner
      if (i == 0) begin : g_first
         assign t_in[i] = afk_pkg::ONE_Q30;
      end else begin : g_next
         assign t_in[i] = t_ff[i-1];
      end

      assign d[i] = 32'(r_ff[i] >> afk_pkg::DIV_SHIFT[i]);

      always_ff @(posedge clock) begin
         if (en) begin
            p_ff[i] <= 63'(car[3*i].x2) * 63'(t_in[i]);
            r_ff[i] <= 65'(p_ff[i][61:30]) * 65'(afk_pkg::DIV_MUL[i]);
            t_ff[i] <= (d[i] >= 32'(afk_pkg::ONE_Q30)) ? '0
                                                       : afk_pkg::ONE_Q30 - 31'(d[i]);
         end
      end
   end

   assign s_val = sprod_ff[61:30];
   assign s_rnd = 17'((33'(s_val) + 33'(1 << 15)) >> 16);
   assign s_cap = (s_rnd > 17'd16384) ? 16'd16384 : 16'(s_rnd);

   always_ff @(posedge clock) begin
      if (en) begin
         sprod_ff <= 62'(car[C].x) * 62'(t_ff[N-1]);
         neg_f_ff <= car[C].neg;
         sine_ff  <= neg_f_ff ? -$signed(s_cap) : $signed(s_cap);
      end
   end

   assign sine = sine_ff;

endmodule

@@ hdl/afk_pose.sv @@
// ----------------------------------------------------------------------------
// afk_pose
// Combines the joint sines and cosines with the link lengths into the
// rotation columns and the saturated end position.
// ----------------------------------------------------------------------------
module afk_pose (
   input  logic                              clock,
   input  logic                              en,
   input  afk_pkg::trig_type                 trig,
   input  logic [afk_pkg::LINK_WIDTH-1:0]    base_height,
   input  logic [afk_pkg::LINK_WIDTH-1:0]    upper_link_length,
   input  logic [afk_pkg::LINK_WIDTH-1:0]    fore_link_length,
   output afk_pkg::rsp_payload_type          rsp
);

   logic signed [31:0] nx_ff, ox_ff, ny_ff, oy_ff;
   logic signed [27:0] reach_ff, lift_ff;
   afk_pkg::trig_type  t1_ff, t2_ff;

   logic signed [43:0] px_ff, py_ff;
   logic signed [15:0] nx2_ff, ox2_ff, ny2_ff, oy2_ff;
   logic signed [27:0] lift2_ff;

   afk_pkg::rsp_payload_type rsp_ff;

   logic signed [10:0] a2, a3;
   logic signed [27:0] bh_q14;

   assign a2     = $signed({1'b0, upper_link_length});
   assign a3     = $signed({1'b0, fore_link_length});
   assign bh_q14 = $signed({4'd0, base_height, 14'd0});

   // Q14 product back to Q14, rounding half up.
   function automatic logic signed [15:0] rnd14(input logic signed [31:0] v);
      logic signed [31:0] b;
      b = v + 32'sd8192;
      return 16'(b >>> 14);
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [43:0] v);
      logic signed [15:0] r;
      if (v > 44'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -44'sd32768) begin
         r = -16'sh8000;
      end else begin
         r = 16'(v);
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff    <= 32'(trig.c4) * 32'(trig.c1);
         ox_ff    <= -(32'(trig.s4) * 32'(trig.c1));
         ny_ff    <= 32'(trig.c4) * 32'(trig.s1);
         oy_ff    <= -(32'(trig.s4) * 32'(trig.s1));
         reach_ff <= 28'(a3) * 28'(trig.c23) + 28'(a2) * 28'(trig.c2);
         lift_ff  <= bh_q14 + 28'(a3) * 28'(trig.s23) + 28'(a2) * 28'(trig.s2);
         t1_ff    <= trig;

         px_ff    <= 44'(t1_ff.c1) * 44'(reach_ff);
         py_ff    <= 44'(t1_ff.s1) * 44'(reach_ff);
         nx2_ff   <= rnd14(nx_ff);
         ox2_ff   <= rnd14(ox_ff);
         ny2_ff   <= rnd14(ny_ff);
         oy2_ff   <= rnd14(oy_ff);
         lift2_ff <= lift_ff;
         t2_ff    <= t1_ff;

         rsp_ff.normal_x   <= nx2_ff;
         rsp_ff.orient_x   <= ox2_ff;
         rsp_ff.approach_x <= t2_ff.s1;
         rsp_ff.normal_y   <= ny2_ff;
         rsp_ff.orient_y   <= oy2_ff;
         rsp_ff.approach_y <= -t2_ff.c1;
         rsp_ff.normal_z   <= t2_ff.s4;
         rsp_ff.orient_z   <= t2_ff.c4;
         rsp_ff.pos_x      <= sat16((px_ff + 44'sd16777216) >>> 25);
         rsp_ff.pos_y      <= sat16((py_ff + 44'sd16777216) >>> 25);
         rsp_ff.pos_z      <= sat16(44'((lift2_ff + 28'sd1024) >>> 11));
      end
   end

   assign rsp = rsp_ff;

endmodule

@@ hdl/arm_forward_kinematics_4dof.sv @@
// ----------------------------------------------------------------------------
// arm_forward_kinematics_4dof
// End pose of a four-joint arm (base yaw and three pitch joints).
// ----------------------------------------------------------------------------
// Usage:
// A joint vector enters on the req_ channel and its pose leaves on the rsp_
// channel; each side moves one transaction at a rising edge where valid is
// high and stall is low. Link lengths and base height are written through
// the csr_ port (index 0 base height, 1 upper link, 2 fore link) while no
// transaction is in flight.
// From acceptance to the result a transaction passes one input stage, 19
// stages of each polynomial sine unit (three per Horner step) and three
// stages that form the products and saturate the positions.
// Throughput is one transaction per cycle unless a stall holds the pipeline;
// the eight sine units run in parallel and every stage moves on each cycle.
// Reset clears all valid bits and loads the register reset values.
// While a result waits with rsp_stall high, the whole pipeline holds its
// contents and req_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module arm_forward_kinematics_4dof (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  afk_pkg::req_payload_type                  req_data,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output afk_pkg::rsp_payload_type                  rsp_data,
   input  logic                                      csr_wr_en,
   input  logic [afk_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [afk_pkg::LINK_WIDTH-1:0]            csr_wdata
);

   localparam int W = afk_pkg::ANGLE_WIDTH;
   localparam int D = afk_pkg::PIPE_DEPTH;

   logic en;
   logic [D-1:0] vld_ff;

   logic [afk_pkg::LINK_WIDTH-1:0] base_height_ff, upper_link_ff, fore_link_ff;

   logic [15:0]  q23, q234;
   logic [W-1:0] ph1, ph2, ph23, ph234;
   logic [W-1:0] phase_in [8];
   logic [W-1:0] phase_ff [8];
   logic signed [15:0] trig_val [8];
   afk_pkg::trig_type trig;

   assign en        = !(vld_ff[D-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[D-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[D-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_height_ff <= afk_pkg::BASE_HEIGHT_RESET;
         upper_link_ff  <= afk_pkg::UPPER_LINK_RESET;
         fore_link_ff   <= afk_pkg::FORE_LINK_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            afk_pkg::CSR_BASE_HEIGHT: base_height_ff <= csr_wdata;
            afk_pkg::CSR_UPPER_LINK:  upper_link_ff  <= csr_wdata;
            afk_pkg::CSR_FORE_LINK:   fore_link_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Joint sums wrap modulo a full turn.
   assign q23   = 16'(req_data.shoulder_angle + req_data.elbow_angle);
   assign q234  = 16'(q23 + req_data.wrist_angle);
   assign ph1   = afk_pkg::to_phase(req_data.base_angle);
   assign ph2   = afk_pkg::to_phase(req_data.shoulder_angle);
   assign ph23  = afk_pkg::to_phase(q23);
   assign ph234 = afk_pkg::to_phase(q234);

   // Even slots take the sine phase, odd slots the phase a quarter turn on.
   assign phase_in[0] = ph1;
   assign phase_in[1] = W'(ph1 + (W'(1) << (W-2)));
   assign phase_in[2] = ph2;
   assign phase_in[3] = W'(ph2 + (W'(1) << (W-2)));
   assign phase_in[4] = ph23;
   assign phase_in[5] = W'(ph23 + (W'(1) << (W-2)));
   assign phase_in[6] = ph234;
   assign phase_in[7] = W'(ph234 + (W'(1) << (W-2)));

   for (genvar k = 0; k < 8; k++) begin : g_sine
      always_ff @(posedge clock) begin
         if (en) begin
            phase_ff[k] <= phase_in[k];
         end
      end

      afk_sine u_sine (
         .clock (clock),
         .en    (en),
         .phase (phase_ff[k]),
         .sine  (trig_val[k])
      );
   end

   assign trig = '{s1: trig_val[0], c1: trig_val[1], s2: trig_val[2], c2: trig_val[3],
                   s23: trig_val[4], c23: trig_val[5], s4: trig_val[6], c4: trig_val[7]};

   afk_pose u_pose (
      .clock             (clock),
      .en                (en),
      .trig              (trig),
      .base_height       (base_height_ff),
      .upper_link_length (upper_link_ff),
      .fore_link_length  (fore_link_ff),
      .rsp               (rsp_data)
   );

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.normal_z >= -16'sd16384 && rsp_data.normal_z <= 16'sd16384 &&
                     rsp_data.orient_z >= -16'sd16384 && rsp_data.orient_z <= 16'sd16384 &&
                     rsp_data.approach_x >= -16'sd16384 && rsp_data.approach_x <= 16'sd16384))
      else $error("rotation entry outside unit range");

   a_normal_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_data.normal_x < 0 ? -rsp_data.normal_x : rsp_data.normal_x) <=
          (rsp_data.orient_z < 0 ? -rsp_data.orient_z : rsp_data.orient_z)))
      else $error("normal_x exceeds |orient_z|: pipeline stages misaligned");

endmodule

@@ test/tb_arm_forward_kinematics_4dof.sv @@
// ----------------------------------------------------------------------------
// tb_arm_forward_kinematics_4dof
// Drives joint vectors into the arm pose pipeline, predicts each pose with a
// bit-accurate polynomial sine model and compares every result field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_arm_forward_kinematics_4dof;

   localparam int LATENCY = 23;

   // Register index that maps to no register.
   localparam logic [afk_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 2'd3;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   afk_pkg::req_payload_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   afk_pkg::rsp_payload_type rsp_data;
   logic csr_wr_en;
   logic [afk_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [afk_pkg::LINK_WIDTH-1:0] csr_wdata;

   // Model copy of the registers.
   logic [9:0] height_reg, upper_reg, fore_reg;

   afk_pkg::rsp_payload_type pose_queue[$];
   int errors;
   bit send_idle_en;
   bit recv_idle_en;
   int hold_cycles;

   arm_forward_kinematics_4dof dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #300ms;
      $display("simulation failed");
      $finish;
   end

   // Sine over a quarter turn, m in 0..16384, result Q14.
   function automatic longint quarter_sin(longint unsigned m);
      longint unsigned x, x2, t, d, s;
      longint unsigned divisor[5];
      divisor = '{110, 72, 42, 20, 6};
      x = (m * 64'd1686629713) >> 14;
      x2 = (x * x) >> 30;
      t = 64'd1 << 30;
      for (int i = 0; i < 5; i++) begin
         d = ((x2 * t) >> 30) / divisor[i];
         t = (d >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - d;
      end
      s = (x * t) >> 30;
      s = (s + (64'd1 << 15)) >> 16;
      if (s > 16384) s = 16384;
      return longint'(s);
   endfunction

   function automatic longint angle_sin(logic [15:0] a);
      longint unsigned r;
      r = a[13:0];
      unique case (a[15:14])
         2'd0: return quarter_sin(r);
         2'd1: return quarter_sin(16384 - r);
         2'd2: return -quarter_sin(r);
         default: return -quarter_sin(16384 - r);
      endcase
   endfunction

   function automatic longint angle_cos(logic [15:0] a);
      return angle_sin(a + 16'h4000);
   endfunction

   // floor((v + 2^(s-1)) / 2^s)
   function automatic longint round_down(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic logic [15:0] clamp16(longint v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   function automatic afk_pkg::rsp_payload_type predict_pose(afk_pkg::req_payload_type j);
      afk_pkg::rsp_payload_type p;
      logic [15:0] q23, q234;
      longint s1, c1, s2, c2, s23, c23, s4, c4, reach, lift;
      q23 = j.shoulder_angle + j.elbow_angle;
      q234 = q23 + j.wrist_angle;
      s1 = angle_sin(j.base_angle);     c1 = angle_cos(j.base_angle);
      s2 = angle_sin(j.shoulder_angle); c2 = angle_cos(j.shoulder_angle);
      s23 = angle_sin(q23);             c23 = angle_cos(q23);
      s4 = angle_sin(q234);             c4 = angle_cos(q234);
      reach = longint'(fore_reg) * c23 + longint'(upper_reg) * c2;
      lift = (longint'(height_reg) << 14) + longint'(fore_reg) * s23
             + longint'(upper_reg) * s2;
      p.normal_x = 16'(round_down(c4 * c1, 14));
      p.orient_x = 16'(round_down(-s4 * c1, 14));
      p.approach_x = 16'(s1);
      p.normal_y = 16'(round_down(c4 * s1, 14));
      p.orient_y = 16'(round_down(-s4 * s1, 14));
      p.approach_y = 16'(-c1);
      p.normal_z = 16'(s4);
      p.orient_z = 16'(c4);
      p.pos_x = clamp16(round_down(c1 * reach, 25));
      p.pos_y = clamp16(round_down(s1 * reach, 25));
      p.pos_z = clamp16(round_down(lift, 11));
      return p;
   endfunction

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
         errors++;
      end
   endtask

   // Result checker.
   always @(posedge clock) begin
      afk_pkg::rsp_payload_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pose_queue.size() == 0) begin
            $error("pose transaction with no expected pose");
            errors++;
         end else begin
            w = pose_queue.pop_front();
            check_field("normal_x", w.normal_x, rsp_data.normal_x);
            check_field("orient_x", w.orient_x, rsp_data.orient_x);
            check_field("approach_x", w.approach_x, rsp_data.approach_x);
            check_field("normal_y", w.normal_y, rsp_data.normal_y);
            check_field("orient_y", w.orient_y, rsp_data.orient_y);
            check_field("approach_y", w.approach_y, rsp_data.approach_y);
            check_field("normal_z", w.normal_z, rsp_data.normal_z);
            check_field("orient_z", w.orient_z, rsp_data.orient_z);
            check_field("pos_x", w.pos_x, rsp_data.pos_x);
            check_field("pos_y", w.pos_y, rsp_data.pos_y);
            check_field("pos_z", w.pos_z, rsp_data.pos_z);
         end
      end
   end

   // Receiver: random stall bursts, or a long counted hold-off on request.
   initial begin
      int burst;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 12);
            rsp_stall <= 1'b1;
            repeat (burst - 1) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Sends one joint vector, with an optional idle burst before it.
   task automatic send_joints(afk_pkg::req_payload_type j);
      if (send_idle_en && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= j;
      pose_queue.push_back(predict_pose(j));
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random(int count);
      afk_pkg::req_payload_type j;
      for (int i = 0; i < count; i++) begin
         j = {$urandom, $urandom};
         send_joints(j);
      end
   endtask

   task automatic drain_pipe();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (pose_queue.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_link_regs(logic [9:0] h, logic [9:0] u, logic [9:0] f);
      csr_wr_en <= 1'b1;
      csr_index <= afk_pkg::CSR_BASE_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_index <= afk_pkg::CSR_UPPER_LINK;
      csr_wdata <= u;
      @(posedge clock);
      csr_index <= afk_pkg::CSR_FORE_LINK;
      csr_wdata <= f;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      height_reg = h;
      upper_reg = u;
      fore_reg = f;
   endtask

   // Extreme angles, quadrant boundaries and sign bits of every field.
   task automatic test_directed_angles();
      logic [15:0] marks[8];
      afk_pkg::req_payload_type j;
      marks = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'h7fff, 16'hffff,
                16'h0001, 16'h3fff};
      foreach (marks[i]) begin
         j = {marks[i], marks[(i + 1) % 8], marks[(i + 3) % 8], marks[(i + 5) % 8]};
         send_joints(j);
      end
      send_joints({16'h0000, 16'h4000, 16'h0000, 16'h0000});
      send_joints({16'h2000, 16'h2000, 16'h2000, 16'h2000});
      send_joints({16'h8000, 16'h8000, 16'h8000, 16'h8000});
      send_joints({16'h5555, 16'haaaa, 16'h1234, 16'hedcb});
      drain_pipe();
   endtask

   // Register settings including both extremes and an unused register index.
   task automatic test_link_settings();
      write_link_regs(10'd1023, 10'd1023, 10'd1023);
      send_joints({16'h0000, 16'h0000, 16'h0000, 16'h0000});
      send_joints({16'h2000, 16'h4000, 16'h0000, 16'h0000});
      send_random(60);
      drain_pipe();
      write_link_regs(10'd0, 10'd0, 10'd0);
      send_joints({16'hc000, 16'h4000, 16'h4000, 16'h0000});
      send_random(60);
      drain_pipe();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_UNUSED_INDEX;
      csr_wdata <= 10'h3ff;
      @(posedge clock);
      write_link_regs(10'($urandom), 10'($urandom), 10'($urandom));
      send_random(200);
      drain_pipe();
   endtask

   // Long receiver hold-off so the pipeline fills and stalls its input.
   task automatic test_backpressure();
      hold_cycles = 80;
      send_random(60);
      drain_pipe();
   endtask

   task automatic test_random_traffic();
      send_random(700);
      drain_pipe();
      send_idle_en = 1'b0;
      recv_idle_en = 1'b0;
      write_link_regs(afk_pkg::BASE_HEIGHT_RESET, afk_pkg::UPPER_LINK_RESET,
                      afk_pkg::FORE_LINK_RESET);
      send_random(300);
      drain_pipe();
   endtask

   initial begin
      errors = 0;
      hold_cycles = 0;
      send_idle_en = 1'b1;
      recv_idle_en = 1'b1;
      height_reg = afk_pkg::BASE_HEIGHT_RESET;
      upper_reg = afk_pkg::UPPER_LINK_RESET;
      fore_reg = afk_pkg::FORE_LINK_RESET;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_angles();
      test_link_settings();
      test_backpressure();
      test_random_traffic();
      if (pose_queue.size() != 0) begin
         $error("%0d expected poses never arrived", pose_queue.size());
         errors++;
      end
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
